// ----- src/fcrt_pkg.sv -----
// Shared types, constants and status codes for the frame chunk reassembly tracker.
package fcrt_pkg;

  localparam int unsigned FCRT_CHUNK_PAYLOAD = 1024;
  localparam int unsigned FCRT_MAX_DATAGRAM  = 2048;
  localparam int unsigned FCRT_HDR_BYTES     = 8;
  localparam int unsigned FCRT_QUEUE_DEPTH   = 2;

  localparam int unsigned LEN_W   = 16;
  localparam int unsigned FID_W   = 32;
  localparam int unsigned CHUNK_W = 16;
  localparam int unsigned OFS_W   = 32;
  localparam int unsigned SIZE_W  = 24;

  localparam logic [SIZE_W-1:0] CAPACITY_RESET = 24'h10_0000;

  typedef enum logic [1:0] {
    ST_RUNT     = 2'd0,
    ST_PROGRESS = 2'd1,
    ST_COMPLETE = 2'd2,
    ST_OVERFLOW = 2'd3
  } fcrt_status_t;

  // Classified datagram as handed from the front to the back.
  typedef struct packed {
    logic               runt;
    logic [FID_W-1:0]   frame_number;
    logic [CHUNK_W-1:0] chunk_count;
    logic [OFS_W-1:0]   offset;
    logic [LEN_W-1:0]   payload;
  } fcrt_item_t;

endpackage

// ----- src/fcrt_channels.sv -----
// Channel interfaces: datagram input, result output and capacity write port.
interface fcrt_dgram_if
  import fcrt_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [LEN_W-1:0]   datagram_length;
  logic [FID_W-1:0]   frame_number;
  logic [CHUNK_W-1:0] chunk_number;
  logic [CHUNK_W-1:0] chunk_count;

  modport source (output valid, datagram_length, frame_number, chunk_number, chunk_count,
                  input ready);
  modport sink   (input valid, datagram_length, frame_number, chunk_number, chunk_count,
                  output ready);
endinterface

interface fcrt_result_if
  import fcrt_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [OFS_W-1:0]   write_offset;
  logic [LEN_W-1:0]   write_length;
  logic [SIZE_W-1:0]  frame_size;
  logic [CHUNK_W-1:0] chunks_seen;
  logic               frame_restarted;

  modport source (output valid, status, write_offset, write_length, frame_size,
                  chunks_seen, frame_restarted, input ready);
  modport sink   (input valid, status, write_offset, write_length, frame_size,
                  chunks_seen, frame_restarted, output ready);
endinterface

interface fcrt_cfg_if
  import fcrt_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- src/fcrt_front.sv -----
// Front end: clamps the length, flags runts and forms the write offset.
module fcrt_front
  import fcrt_pkg::*;
#(
  parameter int unsigned CHUNK_PAYLOAD = FCRT_CHUNK_PAYLOAD,
  parameter int unsigned MAX_DATAGRAM  = FCRT_MAX_DATAGRAM
) (
  fcrt_dgram_if.sink   in_dgram,
  input  logic         q_full,
  output logic         q_push,
  output fcrt_item_t   q_item
);

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_DATAGRAM);
  localparam logic [LEN_W-1:0] HDR_LEN = LEN_W'(FCRT_HDR_BYTES);
  localparam logic [OFS_W-1:0] CHUNK_BYTES = OFS_W'(CHUNK_PAYLOAD);

  logic [LEN_W-1:0] len_clamped;

  assign in_dgram.ready = ~q_full;
  assign q_push         = in_dgram.valid & ~q_full;

  always_comb begin
    len_clamped         = (in_dgram.datagram_length > MAX_LEN) ? MAX_LEN
                                                               : in_dgram.datagram_length;
    q_item.runt         = (len_clamped < HDR_LEN);
    q_item.frame_number = in_dgram.frame_number;
    q_item.chunk_count  = in_dgram.chunk_count;
    q_item.offset       = OFS_W'(in_dgram.chunk_number) * CHUNK_BYTES;
    q_item.payload      = len_clamped - HDR_LEN;
  end

endmodule

// ----- src/fcrt_queue.sv -----
// Short register queue between the front and the back.
module fcrt_queue
  import fcrt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  fcrt_item_t push_item,
  output logic       full,
  input  logic       pop,
  output logic       not_empty,
  output fcrt_item_t head_item
);

  localparam int unsigned PTR_W = (FCRT_QUEUE_DEPTH > 1) ? $clog2(FCRT_QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(FCRT_QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(FCRT_QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(FCRT_QUEUE_DEPTH);

  fcrt_item_t       slot_r [FCRT_QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r,  count_nxt;

  assign full      = (count_r == DEPTH_CNT);
  assign not_empty = (count_r != '0);
  assign head_item = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- src/fcrt_back.sv -----
// Back end: frame state, overflow check, chunk counting and the result register.
module fcrt_back
  import fcrt_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  fcrt_cfg_if.sink      cfg_wr,
  input  logic          q_not_empty,
  input  fcrt_item_t    q_item,
  output logic          q_pop,
  fcrt_result_if.source out_result
);

  localparam logic [CHUNK_W-1:0] CHUNK_MAX = '1;

  logic [SIZE_W-1:0]  capacity_r;
  logic               active_r,   active_nxt;
  logic [FID_W-1:0]   fid_r,      fid_nxt;
  logic [CHUNK_W-1:0] expect_r,   expect_nxt;
  logic [CHUNK_W-1:0] rcvd_r,     rcvd_nxt;
  logic [SIZE_W-1:0]  asm_r,      asm_nxt;

  logic               out_valid_r;
  fcrt_status_t       status_r,   status_nxt;
  logic [OFS_W-1:0]   offset_r,   offset_nxt;
  logic [LEN_W-1:0]   length_r,   length_nxt;
  logic [SIZE_W-1:0]  size_r,     size_nxt;
  logic [CHUNK_W-1:0] seen_r,     seen_nxt;
  logic               restart_r,  restart_nxt;

  logic               take;
  logic               restart;
  logic [CHUNK_W-1:0] base_rcvd, base_expect, new_rcvd;
  logic [SIZE_W-1:0]  base_asm,  new_asm;
  logic [OFS_W:0]     extent;
  logic               overflow;

  assign cfg_wr.ready = 1'b1;
  assign take  = ~out_valid_r | out_result.ready;
  assign q_pop = q_not_empty & take;

  always_comb begin
    restart     = ~active_r | (q_item.frame_number != fid_r);
    base_rcvd   = restart ? '0 : rcvd_r;
    base_asm    = restart ? '0 : asm_r;
    base_expect = restart ? q_item.chunk_count : expect_r;
    extent      = {1'b0, q_item.offset} + (OFS_W + 1)'(q_item.payload);
    overflow    = extent > (OFS_W + 1)'(capacity_r);
    new_asm     = (extent > (OFS_W + 1)'(base_asm)) ? extent[SIZE_W-1:0] : base_asm;
    new_rcvd    = (base_rcvd == CHUNK_MAX) ? base_rcvd : base_rcvd + 1'b1;
  end

  always_comb begin
    active_nxt  = active_r;
    fid_nxt     = fid_r;
    expect_nxt  = expect_r;
    rcvd_nxt    = rcvd_r;
    asm_nxt     = asm_r;
    status_nxt  = ST_RUNT;
    offset_nxt  = '0;
    length_nxt  = '0;
    size_nxt    = asm_r;
    seen_nxt    = rcvd_r;
    restart_nxt = 1'b0;
    if (!q_item.runt) begin
      offset_nxt  = q_item.offset;
      length_nxt  = q_item.payload;
      restart_nxt = restart;
      if (overflow) begin
        status_nxt = ST_OVERFLOW;
        size_nxt   = base_asm;
        seen_nxt   = base_rcvd;
      end else begin
        size_nxt   = new_asm;
        seen_nxt   = new_rcvd;
        status_nxt = (new_rcvd >= base_expect) ? ST_COMPLETE : ST_PROGRESS;
      end
      if (overflow || (new_rcvd >= base_expect)) begin
        active_nxt = 1'b0;
        fid_nxt    = '0;
        expect_nxt = '0;
        rcvd_nxt   = '0;
        asm_nxt    = '0;
      end else begin
        active_nxt = 1'b1;
        fid_nxt    = q_item.frame_number;
        expect_nxt = base_expect;
        rcvd_nxt   = new_rcvd;
        asm_nxt    = new_asm;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r  <= CAPACITY_RESET;
      active_r    <= 1'b0;
      fid_r       <= '0;
      expect_r    <= '0;
      rcvd_r      <= '0;
      asm_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr.valid) begin
        capacity_r <= cfg_wr.data;
      end
      if (q_pop) begin
        active_r <= active_nxt;
        fid_r    <= fid_nxt;
        expect_r <= expect_nxt;
        rcvd_r   <= rcvd_nxt;
        asm_r    <= asm_nxt;
      end
      if (take) begin
        out_valid_r <= q_not_empty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      status_r  <= status_nxt;
      offset_r  <= offset_nxt;
      length_r  <= length_nxt;
      size_r    <= size_nxt;
      seen_r    <= seen_nxt;
      restart_r <= restart_nxt;
    end
  end

  assign out_result.valid           = out_valid_r;
  assign out_result.status          = status_r;
  assign out_result.write_offset    = offset_r;
  assign out_result.write_length    = length_r;
  assign out_result.frame_size      = size_r;
  assign out_result.chunks_seen     = seen_r;
  assign out_result.frame_restarted = restart_r;

endmodule

// ----- src/frame_chunk_reassembly_tracker.sv -----
// Path: an accepted datagram is written into the queue, then popped into the back's result register.
// Throughput: one transaction per cycle while the result is taken; the front runs ahead by up to two queued datagrams
// while the result register is stalled, and the back's state update sets the rate.
// Reset (rst_n low at a clock edge) closes any open frame, empties the queue and output
// register, and sets the buffer capacity to 1 MiB; no clearing pass is needed.
module frame_chunk_reassembly_tracker
  import fcrt_pkg::*;
#(
  parameter int unsigned CHUNK_PAYLOAD = FCRT_CHUNK_PAYLOAD,
  parameter int unsigned MAX_DATAGRAM  = FCRT_MAX_DATAGRAM
) (
  input  logic          clk,
  input  logic          rst_n,
  fcrt_dgram_if.sink    in_dgram,
  fcrt_cfg_if.sink      cfg_wr,
  fcrt_result_if.source out_result
);

  // Handshake between the front end and the queue.
  logic       q_full;
  logic       q_push;
  fcrt_item_t q_push_item;

  // Handshake between the queue and the back end.
  logic       q_pop;
  logic       q_not_empty;
  fcrt_item_t q_head_item;

  // The front end is purely combinational: it clamps the length, detects runts and
  // forms the write offset with a constant multiply, and the queue registers the result.
  fcrt_front #(
    .CHUNK_PAYLOAD (CHUNK_PAYLOAD),
    .MAX_DATAGRAM  (MAX_DATAGRAM)
  ) u_front (
    .in_dgram (in_dgram),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_push_item)
  );

  // The queue lets the input keep accepting transactions while a result waits to be taken.
  fcrt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_item (q_head_item)
  );

  // The back end owns the frame state and the capacity register. It pops one item whenever
  // its output register is free or being emptied in the same cycle, so state updates and
  // results stay in arrival order.
  fcrt_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr      (cfg_wr),
    .q_not_empty (q_not_empty),
    .q_item      (q_head_item),
    .q_pop       (q_pop),
    .out_result  (out_result)
  );

endmodule
